FILE: rtl/trz_pkg.sv
`timescale 1ns / 1ps
// Package for the triangle rasterizer with depth buffer.
// Holds store geometry, command codes and the controller/datapath structs.
package trz_pkg;
    localparam int MaxCols   = 256;
    localparam int MaxRows   = 128;
    localparam int StoreSize = MaxCols * MaxRows;
    localparam int AddrW     = $clog2(StoreSize);
    localparam int ColW      = $clog2(MaxCols) + 1;
    localparam int RowW      = $clog2(MaxRows) + 1;
    localparam int NumW      = 48;
    localparam int DenW      = 24;
    localparam int QW        = 17;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_DRAW  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    typedef struct packed {
        t_cmd        command;
        logic [10:0] vx0, vy0;
        logic [15:0] vz0;
        logic [10:0] vx1, vy1;
        logic [15:0] vz1;
        logic [10:0] vx2, vy2;
        logic [15:0] vz2;
        logic [7:0]  fill_shade;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_shade;
        logic [15:0] pixels_written;
    } t_out_item;

    typedef struct packed {
        logic load;        // capture item, start setup
        logic clr_start;   // reset sweep address
        logic clr_step;    // write one cleared entry, advance
        logic pix_start;   // begin scan at box origin
        logic pix_issue;   // compute pixel, read depth
        logic pix_mul;     // form products
        logic pix_sum;     // sum numerator
        logic div_start;   // start divider
        logic div_step;    // one quotient bit
        logic pix_commit;  // compare and write, advance
        logic rd_issue;    // issue read
        logic rd_take;     // capture read data
        logic res_load;    // move result into output register
    } t_ctl;

    typedef struct packed {
        logic skip;        // draw rejected (off screen or zero area)
        logic setup_done;
        logic clr_last;
        logic div_last;
        logic pix_last;
        logic rd_off;
    } t_sts;
endpackage

FILE: rtl/trz_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interface with a generic payload type.
// Depends on nothing.
interface trz_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/triangle_raster_zbuffer_core.sv
`timescale 1ns / 1ps
// Top level of the triangle rasterizer with shade and depth stores.
// Depends on trz_pkg, trz_if, trz_ctrl, trz_datapath.
//
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      command, vertices, depths, fill_shade
//  out_ch    out  valid/ready      read_shade, pixels_written
//  cfg       in   i_cfg_we         i_cfg_index, i_cfg_data (9 bits)
//
// After acceptance every command passes the setup states; a clear then sweeps every
// store entry, a read fetches the shade (0 off screen), and a rejected draw or unknown
// command goes straight to the result. Draw visits each pixel of the clipped box;
// per pixel the bit-serial depth divider takes 48 steps.
// After reset a clearing pass holds in_ch.ready low.
// A held result stalls only the next result; input is taken meanwhile.
module triangle_raster_zbuffer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [8:0] i_cfg_data,
    trz_if.sink        in_ch,
    trz_if.source      out_ch
);
    import trz_pkg::*;

    logic [8:0] r_cols;
    logic [7:0] r_rows;
    t_ctl ctl;
    t_sts sts;
    t_in_item item;
    t_out_item res;

    assign item = in_ch.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= 9'd80;
            r_rows <= 8'd48;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COLS: r_cols <= i_cfg_data;
                CFG_ROWS: r_rows <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    trz_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready), .i_cmd(item.command),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .o_ctl(ctl), .i_sts(sts)
    );

    trz_datapath u_dp (
        .i_clk(i_clk), .i_ctl(ctl), .o_sts(sts), .i_item(item),
        .i_cols(r_cols), .i_rows(r_rows), .o_result(res)
    );

    assign out_ch.data = res;
endmodule

FILE: rtl/trz_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
// Depends on nothing.
module trz_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: rtl/trz_datapath.sv
`timescale 1ns / 1ps
// Datapath: box setup, edge functions, depth divider and the two stores.
// Depends on trz_pkg and trz_ram.
module trz_datapath (
    input  logic              i_clk,
    input  trz_pkg::t_ctl     i_ctl,
    output trz_pkg::t_sts     o_sts,
    input  trz_pkg::t_in_item i_item,
    input  logic [8:0]        i_cols,
    input  logic [7:0]        i_rows,
    output trz_pkg::t_out_item o_result
);
    import trz_pkg::*;

    logic signed [11:0] r_x0, r_y0, r_x1, r_y1, r_x2, r_y2;
    logic [15:0] r_z0, r_z1, r_z2;
    logic [7:0]  r_shade;
    logic [ColW-1:0] r_cols;
    logic [RowW-1:0] r_rows;
    logic signed [11:0] r_bx0, r_bx1, r_by0, r_by1;
    logic signed [23:0] r_area;
    logic r_skip;
    logic [1:0] r_setup;
    logic signed [11:0] r_px, r_py;
    logic [AddrW-1:0] r_addr;
    logic [AddrW:0]   r_clr;
    logic signed [23:0] r_w0, r_w1, r_w2;
    logic signed [41:0] r_p0, r_p1, r_p2;
    logic [NumW-1:0] r_num;
    logic [DenW-1:0] r_den;
    logic [NumW-1:0] r_rem;
    logic [QW-1:0]   r_quo;
    logic [5:0]      r_dcnt;
    logic r_cov;
    logic [15:0] r_count;
    logic [7:0]  r_rd;
    t_out_item   r_out;

    // setup arithmetic
    logic signed [11:0] mnx, mxx, mny, mxy, cols_s, rows_s;
    logic signed [11:0] ax1, ay1, ax2, ay2;
    always_comb begin
        mnx = (r_x0 < r_x1) ? r_x0 : r_x1; mnx = (r_x2 < mnx) ? r_x2 : mnx;
        mxx = (r_x0 > r_x1) ? r_x0 : r_x1; mxx = (r_x2 > mxx) ? r_x2 : mxx;
        mny = (r_y0 < r_y1) ? r_y0 : r_y1; mny = (r_y2 < mny) ? r_y2 : mny;
        mxy = (r_y0 > r_y1) ? r_y0 : r_y1; mxy = (r_y2 > mxy) ? r_y2 : mxy;
        cols_s = 12'(signed'({1'b0, r_cols}));
        rows_s = 12'(signed'({1'b0, r_rows}));
        ax1 = r_x1 - r_x0; ay1 = r_y1 - r_y0;
        ax2 = r_x2 - r_x0; ay2 = r_y2 - r_y0;
    end

    // edge functions for current pixel
    logic signed [11:0] dx0, dy0, dx1, dy1, dx2, dy2;
    logic signed [23:0] e0, e1, e2;
    always_comb begin
        dx0 = r_x0 - r_px; dy0 = r_y0 - r_py;
        dx1 = r_x1 - r_px; dy1 = r_y1 - r_py;
        dx2 = r_x2 - r_px; dy2 = r_y2 - r_py;
        e0 = dx1 * dy2 - dx2 * dy1;
        e1 = dx2 * dy0 - dx0 * dy2;
        e2 = dx0 * dy1 - dx1 * dy0;
    end

    logic signed [NumW-1:0] sum;
    logic [DenW:0] sub;
    logic [NumW-1:0] shrem;
    logic [15:0] zval;
    logic [15:0] dep_q;
    logic [7:0]  shd_q;
    logic depth_pass;
    logic [AddrW-1:0] ram_addr;
    logic ram_we_clr, ram_we_pix;
    logic [AddrW-1:0] pix_addr;

    always_comb begin
        sum = NumW'(r_p0) + NumW'(r_p1) + NumW'(r_p2);
        if (r_area < 0) sum = -sum;
        shrem = {r_rem[NumW-2:0], r_num[NumW-1]};
        sub = {1'b0, shrem[DenW-1:0]} - {1'b0, r_den};
        zval = (r_quo > QW'(16'hFFFF)) ? 16'hFFFF : r_quo[15:0];
        depth_pass = r_cov && (zval < dep_q);
        pix_addr = AddrW'(r_py[RowW-1:0] * r_cols + r_px[ColW-1:0]);
        ram_we_clr = i_ctl.clr_step;
        ram_we_pix = i_ctl.pix_commit && depth_pass;
        ram_addr = i_ctl.clr_step ? r_clr[AddrW-1:0] : r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x0 <= 12'(signed'(i_item.vx0)); r_y0 <= 12'(signed'(i_item.vy0));
            r_x1 <= 12'(signed'(i_item.vx1)); r_y1 <= 12'(signed'(i_item.vy1));
            r_x2 <= 12'(signed'(i_item.vx2)); r_y2 <= 12'(signed'(i_item.vy2));
            r_z0 <= i_item.vz0; r_z1 <= i_item.vz1; r_z2 <= i_item.vz2;
            r_shade <= i_item.fill_shade;
            r_cols <= (i_cols > 9'(MaxCols)) ? ColW'(MaxCols) : ColW'(i_cols);
            r_rows <= (i_rows > 8'(MaxRows)) ? RowW'(MaxRows) : RowW'(i_rows);
            r_setup <= '0;
            r_count <= '0;
            r_rd <= '0;
            r_px <= 12'(signed'(i_item.vx0));
            r_py <= 12'(signed'(i_item.vy0));
        end else if (r_setup != 2'd3) begin
            r_setup <= r_setup + 2'd1;
            if (r_setup == 2'd0) begin
                r_skip <= (r_cols == '0) || (r_rows == '0) || (mxx < 0) || (mxy < 0)
                          || (mnx >= cols_s) || (mny >= rows_s);
                r_bx0 <= (mnx < 0) ? '0 : mnx;
                r_by0 <= (mny < 0) ? '0 : mny;
                r_bx1 <= (mxx >= cols_s) ? cols_s - 12'sd1 : mxx;
                r_by1 <= (mxy >= rows_s) ? rows_s - 12'sd1 : mxy;
                r_area <= ax1 * ay2 - ax2 * ay1;
            end else if (r_setup == 2'd1) begin
                if (r_area == 0) r_skip <= 1'b1;
                r_den <= (r_area < 0) ? DenW'(-r_area) : DenW'(r_area);
            end
        end
        if (i_ctl.clr_start) r_clr <= '0;
        if (i_ctl.clr_step)  r_clr <= r_clr + 1'b1;
        if (i_ctl.pix_start) begin
            r_px <= r_bx0; r_py <= r_by0;
        end
        if (i_ctl.rd_issue || i_ctl.pix_issue) r_addr <= pix_addr;
        if (i_ctl.pix_issue) begin
            r_w0 <= e0; r_w1 <= e1; r_w2 <= e2;
        end
        if (i_ctl.pix_mul) begin
            r_p0 <= r_w0 * signed'({1'b0, r_z0});
            r_p1 <= r_w1 * signed'({1'b0, r_z1});
            r_p2 <= r_w2 * signed'({1'b0, r_z2});
            r_cov <= (r_area > 0) ? (r_w0 >= 0 && r_w1 >= 0 && r_w2 >= 0)
                                  : (r_w0 <= 0 && r_w1 <= 0 && r_w2 <= 0);
        end
        if (i_ctl.pix_sum) r_num <= (sum < 0) ? '0 : sum;
        if (i_ctl.div_start) begin
            r_rem <= '0; r_quo <= '0; r_dcnt <= 6'(NumW - 1);
        end
        if (i_ctl.div_step) begin
            r_num <= {r_num[NumW-2:0], 1'b0};
            r_dcnt <= r_dcnt - 6'd1;
            if (!sub[DenW] || (shrem[NumW-1:DenW] != '0)) begin
                r_rem <= shrem - NumW'(r_den);
                r_quo <= (r_quo[QW-1]) ? r_quo : {r_quo[QW-2:0], 1'b1};
            end else begin
                r_rem <= shrem;
                r_quo <= (r_quo[QW-1]) ? r_quo : {r_quo[QW-2:0], 1'b0};
            end
        end
        if (i_ctl.pix_commit) begin
            if (depth_pass) r_count <= r_count + 16'd1;
            if (r_px == r_bx1) begin
                r_px <= r_bx0; r_py <= r_py + 12'sd1;
            end else begin
                r_px <= r_px + 12'sd1;
            end
        end
        if (i_ctl.rd_take) r_rd <= o_sts.rd_off ? 8'd0 : shd_q;
        if (i_ctl.res_load) r_out <= {r_rd, r_count};
    end

    trz_ram #(.Width(8), .Depth(StoreSize)) u_shade (
        .i_clk(i_clk), .i_we(ram_we_clr || ram_we_pix), .i_addr(ram_addr),
        .i_wdata(ram_we_clr ? 8'd0 : r_shade), .o_rdata(shd_q)
    );
    trz_ram #(.Width(16), .Depth(StoreSize)) u_depth (
        .i_clk(i_clk), .i_we(ram_we_clr || ram_we_pix), .i_addr(ram_addr),
        .i_wdata(ram_we_clr ? 16'hFFFF : zval), .o_rdata(dep_q)
    );

    always_comb begin
        o_sts.skip       = r_skip;
        o_sts.setup_done = (r_setup == 2'd3);
        o_sts.clr_last   = (r_clr == (AddrW+1)'(StoreSize - 1));
        o_sts.div_last   = (r_dcnt == '0);
        o_sts.pix_last   = (r_px == r_bx1) && (r_py == r_by1);
        o_sts.rd_off     = (r_px < 0) || (r_py < 0) || (r_px >= cols_s) || (r_py >= rows_s);
        o_result         = r_out;
    end
endmodule

FILE: rtl/trz_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences clear sweep, pixel scan and reads.
// Depends on trz_pkg.
module trz_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  trz_pkg::t_cmd i_cmd,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output trz_pkg::t_ctl o_ctl,
    input  trz_pkg::t_sts i_sts
);
    import trz_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_SETUP = 13'b0000000000010,
        S_CLR   = 13'b0000000000100,
        S_ISSUE = 13'b0000000001000,
        S_MUL   = 13'b0000000010000,
        S_SUM   = 13'b0000000100000,
        S_DIV   = 13'b0000001000000,
        S_COMM  = 13'b0000010000000,
        S_RD    = 13'b0000100000000,
        S_RDW   = 13'b0001000000000,
        S_RDT   = 13'b0010000000000,
        S_DONE  = 13'b0100000000000,
        S_BOOT  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic   r_dstart;
    logic   r_out_valid;
    logic   r_boot;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_ctl = '0;
        case (r_state)
            S_BOOT: begin
                o_ctl.clr_start = 1'b1;
                n_state = S_CLR;
            end
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_ctl.load = 1'b1;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if (i_sts.setup_done) begin
                    case (r_cmd)
                        CMD_CLEAR: begin
                            o_ctl.clr_start = 1'b1; n_state = S_CLR;
                        end
                        CMD_DRAW: begin
                            if (i_sts.skip) n_state = S_DONE;
                            else begin
                                o_ctl.pix_start = 1'b1; n_state = S_ISSUE;
                            end
                        end
                        CMD_READ: begin
                            if (i_sts.rd_off) n_state = S_RDT;
                            else n_state = S_RD;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_CLR: begin
                o_ctl.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = r_boot ? S_IDLE : S_DONE;
            end
            S_ISSUE: begin o_ctl.pix_issue = 1'b1; n_state = S_MUL; end
            S_MUL:   begin o_ctl.pix_mul = 1'b1; n_state = S_SUM; end
            S_SUM: begin
                o_ctl.pix_sum = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_dstart) o_ctl.div_start = 1'b1;
                else begin
                    o_ctl.div_step = 1'b1;
                    if (i_sts.div_last) n_state = S_COMM;
                end
            end
            S_COMM: begin
                o_ctl.pix_commit = 1'b1;
                n_state = i_sts.pix_last ? S_DONE : S_ISSUE;
            end
            S_RD:  begin o_ctl.rd_issue = 1'b1; n_state = S_RDW; end
            S_RDW: n_state = S_RDT;
            S_RDT: begin o_ctl.rd_take = 1'b1; n_state = S_DONE; end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_ctl.res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BOOT;
            r_out_valid <= 1'b0;
            r_cmd <= CMD_NONE;
            r_dstart <= 1'b0;
            r_boot <= 1'b1;
        end else begin
            r_state <= n_state;
            r_dstart <= (r_state == S_SUM);
            if (o_ctl.load) r_cmd <= i_cmd;
            if ((r_state == S_CLR) && i_sts.clr_last) r_boot <= 1'b0;
            if (o_ctl.res_load) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready) else $error("ready while busy");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> r_out_valid) else $error("result not raised");
    a_commit_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMM) |-> $past(r_state == S_DIV)) else $error("commit order");
endmodule
